/* sv/yaw_pitch_camera_view_unit_defines.svh */
// Assertion macros for the camera view unit.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef YAW_PITCH_CAMERA_VIEW_UNIT_DEFINES_SVH
`define YAW_PITCH_CAMERA_VIEW_UNIT_DEFINES_SVH

// same-cycle implication
`define YPCV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define YPCV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/ypcv_pkg.sv */
// Shared types and constants for the camera view unit.
// No dependencies.
package ypcv_pkg;

	// angles in Q.16 degrees
	localparam int DEG89  = 5832704;
	localparam int DEG90  = 5898240;
	localparam int DEG180 = 11796480;
	localparam int DEG360 = 23592960;
	localparam int ANG_MAX = 33554431;
	localparam int ANG_MIN = -33554432;

	localparam logic REG_SENS = 1'b0;
	localparam logic REG_ZOOM = 1'b1;

	typedef enum logic [1:0] {
		FN_MOUSE  = 2'd0,
		FN_ZOOM   = 2'd1,
		FN_SETPOS = 2'd2,
		FN_SETROT = 2'd3
	} func_t;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MOUSE = 10'b0000000010,
		S_ZOOM  = 10'b0000000100,
		S_CY0   = 10'b0000001000,
		S_CY1   = 10'b0000010000,
		S_CP0   = 10'b0000100000,
		S_CP1   = 10'b0001000000,
		S_VEC   = 10'b0010000000,
		S_DOT   = 10'b0100000000,
		S_FIN   = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic               start;
		logic signed [25:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] cos_v;
		logic signed [31:0] sin_v;
	} cordic_rsp_t;

	// atan(2^-i) in Q.16 degrees
	function automatic logic [21:0] atan_deg(input logic [4:0] idx);
		logic [21:0] r;
		case (idx)
			5'd0:  r = 22'd2949120;
			5'd1:  r = 22'd1740967;
			5'd2:  r = 22'd919879;
			5'd3:  r = 22'd466945;
			5'd4:  r = 22'd234379;
			5'd5:  r = 22'd117304;
			5'd6:  r = 22'd58666;
			5'd7:  r = 22'd29335;
			5'd8:  r = 22'd14668;
			5'd9:  r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			5'd20: r = 22'd4;
			5'd21: r = 22'd2;
			5'd22: r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

/* sv/ypcv_cordic.sv */
// Iterative rotation-mode CORDIC in degrees, one micro-rotation per cycle.
// Depends on ypcv_pkg.
module ypcv_cordic #(
	parameter int STEPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ypcv_pkg::cordic_req_t req,
	output ypcv_pkg::cordic_rsp_t rsp
);
	import ypcv_pkg::*;

	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [IW-1:0] LAST = IW'(STEPS - 1);
	localparam logic signed [26:0] D90  = 27'(DEG90);
	localparam logic signed [26:0] D180 = 27'(DEG180);
	localparam logic signed [26:0] D360 = 27'(DEG360);

	logic               run_q, done_q, flip_q;
	logic [IW-1:0]      i_q;
	logic signed [33:0] x_q, y_q, dx, dy;
	logic signed [26:0] z_q, at_s;
	logic signed [26:0] a0, a1, a2, a3, a4, r;
	logic               fl;

	// reduce to [-90,90] with a sign flip
	always_comb begin
		a0 = 27'(req.angle);
		a1 = (a0 < 0) ? a0 + D360 : a0;
		a2 = (a1 < 0) ? a1 + D360 : a1;
		a3 = (a2 >= D360) ? a2 - D360 : a2;
		a4 = (a3 >= D180) ? a3 - D360 : a3;
		if (a4 > D90) begin
			r = a4 - D180;
			fl = 1'b1;
		end else if (a4 < -D90) begin
			r = a4 + D180;
			fl = 1'b1;
		end else begin
			r = a4;
			fl = 1'b0;
		end
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at_s = 27'(atan_deg(5'(i_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				i_q <= '0;
			end else if (run_q) begin
				if (i_q == LAST) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= 34'sd652032874;
			y_q <= '0;
			z_q <= r;
			flip_q <= fl;
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at_s;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at_s;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.cos_v = 32'(flip_q ? -x_q : x_q);
	assign rsp.sin_v = 32'(flip_q ? -y_q : y_q);

endmodule

/* sv/yaw_pitch_camera_view_unit.sv */
// Fly camera: yaw/pitch/position state, basis vectors and view translation.
// Depends on ypcv_pkg, ypcv_cordic and yaw_pitch_camera_view_unit_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one event word: func selects
//   mouse move, zoom, set position or set rotation; unused fields are ignored.
//   Output channel (out_valid/out_ready) returns one word per event: right,
//   up and forward vectors (Q1.VEC_FRAC_BITS) and the three translation terms.
//   Config port: wr_en/wr_index/wr_data writes mouse_sensitivity (index 0)
//   or zoom_step (index 1); write only while the block is idle.
// Timing:
//   One event at a time; in_ready is high only when idle. An event runs two
//   serial CORDIC passes (yaw, then pitch), then the vector and dot-product
//   steps on the single shared 32x32 multiplier; a mouse move or a zoom with
//   nonzero scroll first runs its own multiplier steps.
// Reset:
//   State goes to yaw -90, pitch 0, origin; the unit then computes the initial
//   vectors without emitting a word.
// Stall:
//   The result sits in an output register; a receiver that has not taken
//   the previous word holds the unit in its final step until it is taken.
`include "yaw_pitch_camera_view_unit_defines.svh"
module yaw_pitch_camera_view_unit #(
	parameter int CORDIC_STEPS  = 16,
	parameter int VEC_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [15:0]        wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [11:0] mouse_dx,
	input  logic signed [11:0] mouse_dy,
	input  logic signed [7:0]  scroll,
	input  logic signed [31:0] new_pos_x,
	input  logic signed [31:0] new_pos_y,
	input  logic signed [31:0] new_pos_z,
	input  logic signed [25:0] new_yaw,
	input  logic signed [25:0] new_pitch,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_y,
	output logic signed [15:0] right_z,
	output logic signed [15:0] up_x,
	output logic signed [15:0] up_y,
	output logic signed [15:0] up_z,
	output logic signed [15:0] fwd_x,
	output logic signed [15:0] fwd_y,
	output logic signed [15:0] fwd_z,
	output logic signed [31:0] trans_right,
	output logic signed [31:0] trans_up,
	output logic signed [31:0] trans_fwd
);
	import ypcv_pkg::*;

	localparam int VW = VEC_FRAC_BITS + 2;
	localparam int S1 = 30 - VEC_FRAC_BITS;
	localparam int S2 = 60 - VEC_FRAC_BITS;
	localparam int ZS = VEC_FRAC_BITS - 8;
	localparam logic signed [63:0] ZR = (ZS == 0) ? 64'sd0 :
		(64'sd1 <<< ((ZS > 0) ? ZS - 1 : 0));
	localparam logic signed [33:0] D89  = 34'(DEG89);
	localparam logic signed [33:0] D360 = 34'(DEG360);
	localparam logic signed [33:0] AMAX = 34'(ANG_MAX);
	localparam logic signed [33:0] AMIN = 34'(ANG_MIN);

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -66'sd2147483648)
			r = 32'sh80000000;
		else
			r = 32'(v);
		return r;
	endfunction

	// round half up by s bits, clamp to +-1.0
	function automatic logic signed [VW-1:0] to_vec(input logic signed [65:0] v, input int s);
		logic signed [65:0] t, one;
		one = 66'sd1 <<< VEC_FRAC_BITS;
		t = (v + (66'sd1 <<< (s - 1))) >>> s;
		if (t > one)
			t = one;
		else if (t < -one)
			t = -one;
		return VW'(t);
	endfunction

	function automatic logic signed [31:0] to_trans(input logic signed [63:0] d, input logic neg);
		logic signed [65:0] t;
		t = (66'(d) + (66'sd1 <<< (VEC_FRAC_BITS - 1))) >>> VEC_FRAC_BITS;
		if (neg)
			t = -t;
		return sat32(t);
	endfunction

	state_t             state_q;
	logic [4:0]         cnt_q;
	logic [3:0]         op;
	logic               phase, init_q, out_valid_q, out_load;
	logic [15:0]        sens_q, zoom_q;
	logic signed [25:0] yaw_q, pitch_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic signed [11:0] dx_q, dy_q;
	logic signed [7:0]  sc_q;
	logic signed [23:0] f_q;
	logic signed [31:0] cy_q, sy_q, cp_q, sp_q;
	logic signed [VW-1:0] r0_q, r2_q, u0_q, u1_q, u2_q, f0_q, f1_q, f2_q;
	logic signed [63:0] d0_q, d1_q, d2_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p, mul_q;
	logic signed [33:0] yaw_sum, yaw_w1, yaw_w2, yaw_next;
	logic signed [33:0] pitch_sum, pitch_next, setp;
	logic signed [31:0] zpos, zoom_next;
	logic signed [63:0] zadd;
	cordic_req_t        creq;
	cordic_rsp_t        crsp;

	logic signed [15:0] o_r0_q, o_r2_q, o_u0_q, o_u1_q, o_u2_q, o_f0_q, o_f1_q, o_f2_q;
	logic signed [31:0] o_tr_q, o_tu_q, o_tf_q;

	assign op       = cnt_q[4:1];
	assign phase    = cnt_q[0];
	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_FIN) && !init_q && (!out_valid_q || out_ready);

	ypcv_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	assign creq.start = (state_q == S_CY0) || (state_q == S_CP0);
	assign creq.angle = (state_q == S_CY0) ? yaw_q : pitch_q;

	// shared multiplier operand select; product registered in mul_q
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MOUSE: begin
				mul_a = (op == 4'd0) ? 32'(dx_q) : 32'(dy_q);
				mul_b = {16'd0, sens_q};
			end
			S_ZOOM: begin
				case (op)
					4'd0: begin mul_a = 32'(sc_q); mul_b = {16'd0, zoom_q}; end
					4'd1: begin mul_a = 32'(f_q); mul_b = 32'(f0_q); end
					4'd2: begin mul_a = 32'(f_q); mul_b = 32'(f1_q); end
					default: begin mul_a = 32'(f_q); mul_b = 32'(f2_q); end
				endcase
			end
			S_VEC: begin
				case (op)
					4'd0: begin mul_a = cy_q; mul_b = cp_q; end
					4'd1: begin mul_a = sy_q; mul_b = cp_q; end
					4'd2: begin mul_a = cy_q; mul_b = sp_q; end
					default: begin mul_a = sy_q; mul_b = sp_q; end
				endcase
			end
			S_DOT: begin
				case (op)
					4'd0: begin mul_a = 32'(r0_q); mul_b = px_q; end
					4'd1: begin mul_a = '0;        mul_b = py_q; end
					4'd2: begin mul_a = 32'(r2_q); mul_b = pz_q; end
					4'd3: begin mul_a = 32'(u0_q); mul_b = px_q; end
					4'd4: begin mul_a = 32'(u1_q); mul_b = py_q; end
					4'd5: begin mul_a = 32'(u2_q); mul_b = pz_q; end
					4'd6: begin mul_a = 32'(f0_q); mul_b = px_q; end
					4'd7: begin mul_a = 32'(f1_q); mul_b = py_q; end
					default: begin mul_a = 32'(f2_q); mul_b = pz_q; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// mouse: yaw wraps once each way then saturates, pitch clamps to +-89; set-rotation pitch clamps too
	always_comb begin
		yaw_sum   = 34'(yaw_q) + 34'(mul_q);
		yaw_w1    = (yaw_sum < 0) ? yaw_sum + D360 : yaw_sum;
		yaw_w2    = (yaw_w1 > D360) ? yaw_w1 - D360 : yaw_w1;
		yaw_next  = (yaw_w2 > AMAX) ? AMAX : ((yaw_w2 < AMIN) ? AMIN : yaw_w2);
		pitch_sum = 34'(pitch_q) + 34'(mul_q);
		pitch_next = (pitch_sum > D89) ? D89 : ((pitch_sum < -D89) ? -D89 : pitch_sum);
		setp      = 34'(new_pitch);
		if (setp > D89)
			setp = D89;
		else if (setp < -D89)
			setp = -D89;
	end

	// zoom: step along the stored forward vector
	always_comb begin
		case (op)
			4'd1: zpos = px_q;
			4'd2: zpos = py_q;
			default: zpos = pz_q;
		endcase
		zadd = (mul_q + ZR) >>> ZS;
		zoom_next = sat32(66'(zpos) + 66'(zadd));
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CY0;
			cnt_q       <= '0;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
			sens_q      <= 16'd3277;
			zoom_q      <= 16'd512;
			yaw_q       <= -26'(DEG90);
			pitch_q     <= '0;
			px_q        <= '0;
			py_q        <= '0;
			pz_q        <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_SENS: sens_q <= wr_data;
					default:  zoom_q <= wr_data;
				endcase
			end
			// output word: set on load, cleared when taken
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						case (func_t'(func))
							FN_MOUSE: state_q <= S_MOUSE;
							FN_ZOOM:  state_q <= (scroll == 8'sd0) ? S_CY0 : S_ZOOM;
							FN_SETPOS: begin
								px_q <= new_pos_x;
								py_q <= new_pos_y;
								pz_q <= new_pos_z;
								state_q <= S_CY0;
							end
							default: begin
								yaw_q   <= new_yaw;
								pitch_q <= 26'(setp);
								state_q <= S_CY0;
							end
						endcase
					end
				end
				S_MOUSE: begin
					if (phase) begin
						if (op == 4'd0) begin
							yaw_q <= 26'(yaw_next);
							cnt_q <= cnt_q + 1'b1;
						end else begin
							pitch_q <= 26'(pitch_next);
							cnt_q   <= '0;
							state_q <= S_CY0;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ZOOM: begin
					if (phase) begin
						case (op)
							4'd0: cnt_q <= cnt_q + 1'b1;
							4'd1: begin
								px_q  <= zoom_next;
								cnt_q <= cnt_q + 1'b1;
							end
							4'd2: begin
								py_q  <= zoom_next;
								cnt_q <= cnt_q + 1'b1;
							end
							default: begin
								pz_q    <= zoom_next;
								cnt_q   <= '0;
								state_q <= S_CY0;
							end
						endcase
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_CY0: state_q <= S_CY1;
				S_CY1: if (crsp.done) state_q <= S_CP0;
				S_CP0: state_q <= S_CP1;
				S_CP1: begin
					cnt_q <= '0;
					if (crsp.done)
						state_q <= S_VEC;
				end
				S_VEC: begin
					if (phase && op == 4'd3) begin
						cnt_q   <= '0;
						state_q <= S_DOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DOT: begin
					if (phase && op == 4'd8) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					if (init_q) begin
						init_q  <= 1'b0;
						state_q <= S_IDLE;
					end else if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		if (state_q == S_IDLE && in_valid) begin
			dx_q <= mouse_dx;
			dy_q <= mouse_dy;
			sc_q <= scroll;
		end
		if (state_q == S_ZOOM && phase && op == 4'd0)
			f_q <= 24'(mul_q);
		if (state_q == S_CY1 && crsp.done) begin
			cy_q <= crsp.cos_v;
			sy_q <= crsp.sin_v;
		end
		if (state_q == S_CP1 && crsp.done) begin
			cp_q <= crsp.cos_v;
			sp_q <= crsp.sin_v;
			f1_q <= to_vec(66'(crsp.sin_v), S1);
			u1_q <= to_vec(66'(crsp.cos_v), S1);
			r0_q <= to_vec(-66'(sy_q), S1);
			r2_q <= to_vec(66'(cy_q), S1);
		end
		if (state_q == S_VEC && phase) begin
			case (op)
				4'd0: f0_q <= to_vec(66'(mul_q), S2);
				4'd1: f2_q <= to_vec(66'(mul_q), S2);
				4'd2: u0_q <= to_vec(-66'(mul_q), S2);
				default: begin
					u2_q <= to_vec(-66'(mul_q), S2);
					d0_q <= '0;
					d1_q <= '0;
					d2_q <= '0;
				end
			endcase
		end
		if (state_q == S_DOT && phase) begin
			if (op < 4'd3)
				d0_q <= d0_q + mul_q;
			else if (op < 4'd6)
				d1_q <= d1_q + mul_q;
			else
				d2_q <= d2_q + mul_q;
		end
		if (out_load) begin
			o_r0_q <= 16'(r0_q);
			o_r2_q <= 16'(r2_q);
			o_u0_q <= 16'(u0_q);
			o_u1_q <= 16'(u1_q);
			o_u2_q <= 16'(u2_q);
			o_f0_q <= 16'(f0_q);
			o_f1_q <= 16'(f1_q);
			o_f2_q <= 16'(f2_q);
			o_tr_q <= to_trans(d0_q, 1'b1);
			o_tu_q <= to_trans(d1_q, 1'b1);
			o_tf_q <= to_trans(d2_q, 1'b0);
		end
	end

	assign out_valid   = out_valid_q;
	assign right_x     = o_r0_q;
	assign right_y     = '0;
	assign right_z     = o_r2_q;
	assign up_x        = o_u0_q;
	assign up_y        = o_u1_q;
	assign up_z        = o_u2_q;
	assign fwd_x       = o_f0_q;
	assign fwd_y       = o_f1_q;
	assign fwd_z       = o_f2_q;
	assign trans_right = o_tr_q;
	assign trans_up    = o_tu_q;
	assign trans_fwd   = o_tf_q;

	`YPCV_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")
	`YPCV_ASSERT_NOW(a_pitch_range, 1'b1, pitch_q <= 26'(DEG89) && pitch_q >= -26'(DEG89), "pitch out of range")
	`YPCV_ASSERT_NOW(a_no_word_in_init, init_q, !out_valid_q, "word emitted during init")

endmodule
